// ----- rtl/core/itra_pkg.sv -----
// ----------------------------------------------------------------------------
// itra_pkg
// Shared types, constants and the digit-to-ASCII map for the radix ASCII
// converter.
// ----------------------------------------------------------------------------
package itra_pkg;

    // Fixed field widths
    localparam int VALUE_W    = 16;
    localparam int RADIX_W    = 8;
    localparam int CHAR_W     = 8;
    localparam int BASE_W     = 5;   // holds a valid radix, 2 to 16
    localparam int DIGIT_W    = 4;

    // Radix limits
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 8'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 8'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 8'd10;

    // Character sent with an invalid radix
    localparam logic [CHAR_W-1:0] INVALID_CHAR = 8'h00;

    // Front-to-back queue (depth must be a power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Classification made by the front end
    typedef enum logic [1:0] {
        KIND_NORMAL,
        KIND_ZERO,
        KIND_INVALID
    } item_kind_t;

    // One queued conversion job
    typedef struct packed {
        item_kind_t          kind;
        logic [BASE_W-1:0]   base;
        logic [VALUE_W-1:0]  value;
    } item_t;

    // Digit 0..15 to '0'..'9', 'A'..'F'
    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        case (d)
            4'd0:    c = 8'h30;
            4'd1:    c = 8'h31;
            4'd2:    c = 8'h32;
            4'd3:    c = 8'h33;
            4'd4:    c = 8'h34;
            4'd5:    c = 8'h35;
            4'd6:    c = 8'h36;
            4'd7:    c = 8'h37;
            4'd8:    c = 8'h38;
            4'd9:    c = 8'h39;
            4'd10:   c = 8'h41;
            4'd11:   c = 8'h42;
            4'd12:   c = 8'h43;
            4'd13:   c = 8'h44;
            4'd14:   c = 8'h45;
            default: c = 8'h46;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/integer_to_radix_ascii_unit.sv -----
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_unit
// Converts an unsigned value to ASCII digits in a radix of 2 to 16, most
// significant digit first, last digit marked.
//
// Channel   Dir  Signals                       Content
// cfg       in   cfg_wr_en, cfg_wr_data        radix register (reset 10)
// s_axis    in   tvalid, tready, tdata[15:0]   value
// m_axis    out  tvalid, tready, tdata[7:0]    digit_char; tlast last_digit;
//                                              tuser invalid_radix
//
// Each digit costs one pass through the shared divider (four quotient bits
// per cycle); the job is taken from the queue first, and the buffered digits
// are sent after the last division.
// Zero and invalid-radix jobs skip the divider and give one transaction.
// A two-entry job queue lets inputs be taken while a conversion runs.
// Output stalls hold the engine only; reset is asynchronous, active low.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_unit
    import itra_pkg::*;
#(
    parameter int VALUE_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [RADIX_W-1:0] cfg_wr_data,    // [7:0] radix
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [VALUE_W-1:0] s_axis_tdata,   // [15:0] value
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [CHAR_W-1:0]  m_axis_tdata,   // [7:0] digit_char
    output logic               m_axis_tlast,   // last_digit
    output logic               m_axis_tuser    // invalid_radix
);

    localparam int DW = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

    logic               q_wr_valid;
    logic               q_wr_ready;
    item_t              q_wr_item;
    logic               q_rd_valid;
    logic               q_rd_ready;
    item_t              q_rd_item;
    logic               div_start;
    logic [DW-1:0]      div_dividend;
    logic [BASE_W-1:0]  div_divisor;
    logic               div_done;
    logic [DW-1:0]      div_quotient;
    logic [DIGIT_W-1:0] div_remainder;

    // Front end: radix register and job classification
    itra_front #(
        .DW (DW)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_wr_valid    (q_wr_valid),
        .q_wr_ready    (q_wr_ready),
        .q_wr_item     (q_wr_item)
    );

    // Job queue
    itra_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_item  (q_wr_item),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_item  (q_rd_item)
    );

    // Shared divider
    itra_div #(
        .DW (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // Conversion engine and output register
    itra_back #(
        .DW (DW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_rd_valid    (q_rd_valid),
        .q_rd_ready    (q_rd_ready),
        .q_rd_item     (q_rd_item),
        .div_start     (div_start),
        .div_dividend  (div_dividend),
        .div_divisor   (div_divisor),
        .div_done      (div_done),
        .div_quotient  (div_quotient),
        .div_remainder (div_remainder),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

`ifndef SYNTHESIS
    // Invalid radix gives a single zero character with the last mark
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == INVALID_CHAR)
        else $error("invalid-radix transaction malformed");

    // A valid digit is always a hex character
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            (m_axis_tdata >= 8'h30 && m_axis_tdata <= 8'h39) ||
            (m_axis_tdata >= 8'h41 && m_axis_tdata <= 8'h46))
        else $error("digit character out of range");

    // The divider never finishes in the cycle right after a start
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> !div_done)
        else $error("divider done too early");
`endif

endmodule

// ----- rtl/core/itra_front.sv -----
// ----------------------------------------------------------------------------
// itra_front
// Holds the radix register, accepts input transactions, masks the value and
// classifies each job as normal, zero or invalid radix.
// ----------------------------------------------------------------------------
module itra_front
    import itra_pkg::*;
#(
    parameter int DW = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [RADIX_W-1:0] cfg_wr_data,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [VALUE_W-1:0] s_axis_tdata,     // [15:0] value
    output logic               q_wr_valid,
    input  logic               q_wr_ready,
    output item_t              q_wr_item
);

    logic [RADIX_W-1:0] radix_reg;
    logic [VALUE_W-1:0] value_masked;
    logic               radix_bad;

    // Radix register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (cfg_wr_en)
        begin
            radix_reg <= cfg_wr_data;
        end
    end

    // Mask and classify
    always_comb
    begin
        value_masked = VALUE_W'(s_axis_tdata[DW-1:0]);
        radix_bad    = (radix_reg < RADIX_MIN) || (radix_reg > RADIX_MAX);

        q_wr_item.value = value_masked;
        q_wr_item.base  = radix_reg[BASE_W-1:0];
        if (radix_bad)
        begin
            q_wr_item.kind = KIND_INVALID;
        end
        else if (value_masked == '0)
        begin
            q_wr_item.kind = KIND_ZERO;
        end
        else
        begin
            q_wr_item.kind = KIND_NORMAL;
        end
    end

    assign q_wr_valid    = s_axis_tvalid;
    assign s_axis_tready = q_wr_ready;

endmodule

// ----- rtl/core/itra_queue.sv -----
// ----------------------------------------------------------------------------
// itra_queue
// Short job queue between the front end and the conversion engine.
// ----------------------------------------------------------------------------
module itra_queue
    import itra_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  item_t wr_item,
    output logic  rd_valid,
    input  logic  rd_ready,
    output item_t rd_item
);

    item_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_CW-1:0]  count_reg;
    logic                 push;
    logic                 pop;

    assign wr_ready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QUEUE_CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QUEUE_CW'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ----- rtl/core/itra_div.sv -----
// ----------------------------------------------------------------------------
// itra_div
// Iterative restoring divider by a small radix, four quotient bits a cycle.
// ----------------------------------------------------------------------------
module itra_div
    import itra_pkg::*;
#(
    parameter int DW = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DW-1:0]      dividend,
    input  logic [BASE_W-1:0]  divisor,
    output logic               done,
    output logic [DW-1:0]      quotient,
    output logic [DIGIT_W-1:0] remainder
);

    localparam int STEPS = 4;
    localparam int ITER  = (DW + STEPS - 1) / STEPS;
    localparam int PW    = ITER * STEPS;
    localparam int IW    = $clog2(ITER + 1);

    logic [PW-1:0]      work_reg;
    logic [DIGIT_W-1:0] rem_reg;
    logic [BASE_W-1:0]  divisor_reg;
    logic [IW-1:0]      iter_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [PW-1:0]      work_next;
    logic [DIGIT_W-1:0] rem_next;

    // Four compare-and-subtract steps on the 5-bit partial remainder
    always_comb
    begin
        logic [BASE_W-1:0] r;
        logic [PW-1:0]     w;
        r = BASE_W'(rem_reg);
        w = work_reg;
        for (int i = 0; i < STEPS; i++)
        begin
            r = {r[DIGIT_W-1:0], w[PW-1]};
            w = {w[PW-2:0], 1'b0};
            if (r >= divisor_reg)
            begin
                r    = r - divisor_reg;
                w[0] = 1'b1;
            end
        end
        work_next = w;
        rem_next  = r[DIGIT_W-1:0];
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg    <= '0;
            rem_reg     <= '0;
            divisor_reg <= '0;
            iter_reg    <= '0;
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            // one-cycle pulse after the last iteration
            done_reg <= !start && busy_reg && (iter_reg == IW'(1));
            if (start)
            begin
                work_reg    <= PW'(dividend);
                rem_reg     <= '0;
                divisor_reg <= divisor;
                iter_reg    <= IW'(ITER);
                busy_reg    <= 1'b1;
            end
            else if (busy_reg)
            begin
                work_reg <= work_next;
                rem_reg  <= rem_next;
                iter_reg <= iter_reg - IW'(1);
                if (iter_reg == IW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = work_reg[DW-1:0];
    assign remainder = rem_reg;

endmodule

// ----- rtl/core/itra_back.sv -----
// ----------------------------------------------------------------------------
// itra_back
// Conversion engine: takes jobs from the queue, peels digits off with the
// divider into a digit buffer, then sends them most significant first.
// ----------------------------------------------------------------------------
module itra_back
    import itra_pkg::*;
#(
    parameter int DW = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_rd_valid,
    output logic               q_rd_ready,
    input  item_t              q_rd_item,
    output logic               div_start,
    output logic [DW-1:0]      div_dividend,
    output logic [BASE_W-1:0]  div_divisor,
    input  logic               div_done,
    input  logic [DW-1:0]      div_quotient,
    input  logic [DIGIT_W-1:0] div_remainder,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [CHAR_W-1:0]  m_axis_tdata,
    output logic               m_axis_tlast,
    output logic               m_axis_tuser
);

    localparam int AW = $clog2(DW);
    localparam int CW = $clog2(DW + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t             state_reg;
    logic [DW-1:0]      val_reg;
    logic [BASE_W-1:0]  base_reg;
    logic [CW-1:0]      cnt_reg;
    logic               inv_reg;
    logic               start_reg;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               out_last_reg;
    logic               out_inv_reg;

    logic [DIGIT_W-1:0] digit_reg [DW];

    logic               out_free;
    logic [CW-1:0]      cnt_dec;
    logic [AW-1:0]      rd_idx;
    logic               buf_we;
    logic [AW-1:0]      buf_idx;
    logic [DIGIT_W-1:0] buf_data;

    assign out_free   = !out_valid_reg || m_axis_tready;
    assign cnt_dec    = cnt_reg - CW'(1);
    assign rd_idx     = cnt_dec[AW-1:0];
    assign q_rd_ready = (state_reg == ST_IDLE);

    // Digit buffer write: zero digit on a zero job, remainders while dividing
    always_comb
    begin
        buf_we   = 1'b0;
        buf_idx  = cnt_reg[AW-1:0];
        buf_data = div_remainder;
        if (state_reg == ST_IDLE && q_rd_valid && q_rd_item.kind == KIND_ZERO)
        begin
            buf_we   = 1'b1;
            buf_idx  = '0;
            buf_data = '0;
        end
        else if (state_reg == ST_DIV && div_done)
        begin
            buf_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            digit_reg[buf_idx] <= buf_data;
        end
    end

    // Job sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            val_reg       <= '0;
            base_reg      <= '0;
            cnt_reg       <= '0;
            inv_reg       <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_last_reg  <= 1'b0;
            out_inv_reg   <= 1'b0;
        end
        else
        begin
            // divider start on a new normal job or a non-zero quotient
            start_reg <= (state_reg == ST_IDLE && q_rd_valid &&
                          q_rd_item.kind == KIND_NORMAL) ||
                         (state_reg == ST_DIV && div_done && div_quotient != '0);
            if (m_axis_tready && state_reg != ST_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (q_rd_valid)
                    begin
                        case (q_rd_item.kind)
                            KIND_NORMAL:
                            begin
                                inv_reg   <= 1'b0;
                                cnt_reg   <= '0;
                                val_reg   <= q_rd_item.value[DW-1:0];
                                base_reg  <= q_rd_item.base;
                                state_reg <= ST_DIV;
                            end
                            KIND_ZERO:
                            begin
                                inv_reg   <= 1'b0;
                                cnt_reg   <= CW'(1);
                                state_reg <= ST_EMIT;
                            end
                            default:
                            begin
                                inv_reg   <= 1'b1;
                                cnt_reg   <= CW'(1);
                                state_reg <= ST_EMIT;
                            end
                        endcase
                    end
                end

                ST_DIV:
                begin
                    if (div_done)
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                        if (div_quotient == '0)
                        begin
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            val_reg <= div_quotient;
                        end
                    end
                end

                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_char_reg  <= inv_reg ? INVALID_CHAR : digit_ascii(digit_reg[rd_idx]);
                        out_last_reg  <= (cnt_reg == CW'(1));
                        out_inv_reg   <= inv_reg;
                        cnt_reg       <= cnt_dec;
                        if (cnt_reg == CW'(1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign div_start     = start_reg;
    assign div_dividend  = val_reg;
    assign div_divisor   = base_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_inv_reg;

endmodule
